[hdl/bb3_pkg.sv]
// Shared constants and types for the clipped 3x3 box blur.
package bb3_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W      = 8;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int FW_W   = 8;
	localparam int FH_W   = 11;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	// column sum of up to 3 pixels, window sum of up to 9
	localparam int CSUM_W = PIX_W + 2;
	localparam int SUM_W  = PIX_W + 4;
	localparam int CNT_W  = 4;

	// divisor counts of a clipped window
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);
	localparam logic [CNT_W-1:0] CNT_SIX   = CNT_W'(6);
	localparam int CNT_NINE = 9;

	// reciprocal multiply, exact for dividends below 2**15
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP_ONE   = RECIP_W'(65536);
	localparam logic [RECIP_W-1:0] RECIP_THREE = RECIP_W'(21846);
	localparam logic [RECIP_W-1:0] RECIP_NINE  = RECIP_W'(7282);
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam int NUM_RES = 4;
	localparam int QDEPTH  = 8;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QPTR_W + 1;
	localparam int RES_W   = QCNT_W + 1;

	localparam int TDATA_OUT_W = 32;
	localparam int TDATA_IN_W  = 8;

	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] prev;
	} line_word_t;

	// one window column, oldest row first
	typedef struct packed {
		logic [PIX_W-1:0] p0;
		logic [PIX_W-1:0] p1;
		logic [PIX_W-1:0] p2;
	} col_t;

	typedef struct packed {
		logic row0_en;  // row two above is inside the frame
		logic row1_en;  // row above is inside the frame
	} row_mask_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             row0_en;
		logic             row1_en;
		logic             col0_en;
		logic             col1_en;
		logic             bot_en;
		logic             right_en;
		logic             fend;
	} ctrl_t;

	// results caused by one input pixel, row-major order
	typedef struct packed {
		logic [ROW_W-1:0]                row;
		logic [COL_W-1:0]                col;
		logic [NUM_RES-1:0]              mask;
		logic                            fend;
		logic [NUM_RES-1:0][PIX_W-1:0]   pix;
	} bundle_t;

endpackage

[hdl/bb3_line_store.sv]
// Two-row line store, one word per column, registered read.
module bb3_line_store (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [bb3_pkg::COL_W-1:0] wr_addr,
	input  bb3_pkg::line_word_t      wr_data,
	input  logic                     rd_en,
	input  logic [bb3_pkg::COL_W-1:0] rd_addr,
	output bb3_pkg::line_word_t      rd_data
);
	import bb3_pkg::*;

	line_word_t mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hdl/bb3_cell.sv]
// One window column cell: holds three pixels and passes them left on a shift.
module bb3_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  bb3_pkg::col_t              col_in,
	input  bb3_pkg::row_mask_t         mask,
	output bb3_pkg::col_t              col_out,
	output logic [bb3_pkg::CSUM_W-1:0] top_sum,
	output logic [bb3_pkg::CSUM_W-1:0] bot_sum
);
	import bb3_pkg::*;

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// top window spans all three rows, bottom window the lower two
	assign top_sum = (mask.row0_en ? CSUM_W'(col_q.p0) : CSUM_W'(0))
		+ CSUM_W'(col_q.p1) + CSUM_W'(col_q.p2);
	assign bot_sum = (mask.row1_en ? CSUM_W'(col_q.p1) : CSUM_W'(0))
		+ CSUM_W'(col_q.p2);

endmodule

[hdl/bb3_mean.sv]
// Rounded window mean: divide by the clipped count via reciprocal multiply.
module bb3_mean (
	input  logic                      clk,
	input  logic [bb3_pkg::SUM_W-1:0] sum,
	input  logic [bb3_pkg::CNT_W-1:0] cnt,
	output logic [bb3_pkg::PIX_W-1:0] mean
);
	import bb3_pkg::*;

	logic [SUM_W-1:0]   half_adj;
	logic [SUM_W-1:0]   op;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod_s1;

	// (2*sum + n) / (2*n) == (sum + n/2) / n
	assign half_adj = sum + SUM_W'(cnt >> 1);

	always_comb begin
		case (cnt)
			CNT_ONE: begin
				op    = half_adj;
				recip = RECIP_ONE;
			end
			CNT_TWO: begin
				op    = half_adj >> 1;
				recip = RECIP_ONE;
			end
			CNT_THREE: begin
				op    = half_adj;
				recip = RECIP_THREE;
			end
			CNT_FOUR: begin
				op    = half_adj >> 2;
				recip = RECIP_ONE;
			end
			CNT_SIX: begin
				op    = half_adj >> 1;
				recip = RECIP_THREE;
			end
			default: begin
				op    = half_adj;
				recip = RECIP_NINE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op) * PROD_W'(recip);
	end

	assign mean = prod_s1[RECIP_SHIFT +: PIX_W];

endmodule

[hdl/bb3_out_queue.sv]
// Result queue: one entry per input pixel that causes results, drained one result per transaction.
module bb3_out_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  bb3_pkg::bundle_t            push_data,
	output logic [bb3_pkg::QCNT_W-1:0]  count,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bb3_pkg::TDATA_OUT_W-1:0] m_tdata,  // pixel_out, out_row, out_col, pad
	output logic                        m_tlast,  // run_last
	output logic                        m_tuser   // frame_end
);
	import bb3_pkg::*;

	bundle_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [NUM_RES-1:0]  done_q;

	bundle_t             head;
	logic [NUM_RES-1:0]  avail;
	logic [NUM_RES-1:0]  sel;
	logic                last;
	logic                pop;
	logic                pop_entry;
	logic [PIX_W-1:0]    pix;
	logic [ROW_W-1:0]    row;
	logic [COL_W-1:0]    col;

	assign head  = mem_q[rd_ptr_q];
	assign avail = head.mask & ~done_q;
	assign sel   = avail & (~avail + NUM_RES'(1));
	assign last  = (avail & ~sel) == '0;

	assign m_tvalid  = count_q != '0;
	assign pop       = m_tvalid && m_tready;
	assign pop_entry = pop && last;
	assign count     = count_q;

	always_comb begin
		case (sel)
			4'b0001: begin
				pix = head.pix[0];
				row = head.row - ROW_W'(1);
				col = head.col - COL_W'(1);
			end
			4'b0010: begin
				pix = head.pix[1];
				row = head.row - ROW_W'(1);
				col = head.col;
			end
			4'b0100: begin
				pix = head.pix[2];
				row = head.row;
				col = head.col - COL_W'(1);
			end
			default: begin
				pix = head.pix[3];
				row = head.row;
				col = head.col;
			end
		endcase
	end

	assign m_tdata = {(TDATA_OUT_W - PIX_W - ROW_W - COL_W)'(0), col, row, pix};
	assign m_tlast = last;
	assign m_tuser = last && head.fend;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				if (last) begin
					rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
					done_q   <= '0;
				end else begin
					done_q <= done_q | sel;
				end
			end
			case ({push, pop_entry})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/box_blur_3x3_clipped.sv]
// Top level of the clipped 3x3 box blur over a raster pixel stream.
//
// Pixels enter on the s_ stream in raster order, one per transaction. Frame
// width and height are written on the cfg_ channel while the block is idle;
// a write to either register restarts the frame at row 0, column 0.
// Each output pixel is the rounded mean of its 3x3 window clipped to the
// frame. It leaves on the m_ stream as soon as its window is complete, so one
// input pixel causes 0 to 4 results; m_tlast marks the last result caused by
// an input pixel and m_tuser the final result of the frame.
// The first result of a pixel passes the line store read, window shift, window
// sums and mean multiply, and is offered once it heads the result queue.
// Throughput: while m_tready is high, one pixel per cycle as long as each pixel
// causes at most one result; the output port moves one result per cycle, so at
// the right edge and on the last row input is held back by the 8-entry result
// queue. s_tready drops when queued plus in-flight pixels would fill that
// queue, so a stalled receiver stalls the input and nothing is lost.
// Reset clears the position, the pipeline and the queue; width and height
// return to 1. Line store contents are not cleared: entries read before being
// written in a frame only fall outside the frame and never reach a result.
module box_blur_3x3_clipped (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bb3_pkg::TDATA_IN_W-1:0]    s_tdata,   // pixel_in
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bb3_pkg::TDATA_OUT_W-1:0]   m_tdata,   // pixel_out, out_row, out_col, pad
	output logic                              m_tlast,   // run_last
	output logic                              m_tuser,   // frame_end
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bb3_pkg::*;

	// configuration and position
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic             cfg_wr;
	logic             cfg_hit;
	logic             s_accept;
	ctrl_t            ctrl_in;

	// pipeline
	logic             v_s1, v_s2, v_s3, v_s4;
	ctrl_t            ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [PIX_W-1:0] pix_s1;
	logic             fwd_s1;
	line_word_t       fwd_word_s1;
	line_word_t       rd_word;
	line_word_t       eff_word;
	line_word_t       wr_word;
	col_t             new_col;

	col_t              cell_col [3];
	logic [CSUM_W-1:0] top_sum [3];
	logic [CSUM_W-1:0] bot_sum [3];
	row_mask_t         rmask;

	logic [NUM_RES-1:0]            mask_s2;
	logic [NUM_RES-1:0][SUM_W-1:0] sum_s2;
	logic [NUM_RES-1:0][CNT_W-1:0] cnt_s2;
	logic [NUM_RES-1:0][SUM_W-1:0] sum_s3;
	logic [NUM_RES-1:0][CNT_W-1:0] cnt_s3;
	logic [NUM_RES-1:0]            mask_s3;
	logic [NUM_RES-1:0]            mask_s4;
	logic [NUM_RES-1:0][PIX_W-1:0] mean_s4;
	logic [CNT_W-1:0]              rows_top, rows_bot, cols_l, cols_r;

	bundle_t           push_data;
	logic              push;
	logic [QCNT_W-1:0] q_count;
	logic [RES_W-1:0]  reserved;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		if (fw_q == '0) begin
			wm1 = '0;
		end else if (fw_q > FW_W'(MAX_WIDTH)) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(fw_q - FW_W'(1));
		end
		if (fh_q == '0) begin
			hm1 = '0;
		end else if (fh_q > FH_W'(MAX_HEIGHT)) begin
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_W'(fh_q - FH_W'(1));
		end
	end

	// ---------------- input side ----------------
	assign reserved = RES_W'(q_count) + RES_W'(v_s1) + RES_W'(v_s2)
		+ RES_W'(v_s3) + RES_W'(v_s4);
	assign s_tready = reserved < RES_W'(QDEPTH);
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		ctrl_in.row      = row_q;
		ctrl_in.col      = col_q;
		ctrl_in.row0_en  = row_q >= ROW_W'(2);
		ctrl_in.row1_en  = row_q != '0;
		ctrl_in.col0_en  = col_q >= COL_W'(2);
		ctrl_in.col1_en  = col_q != '0;
		ctrl_in.bot_en   = row_q == hm1;
		ctrl_in.right_en = col_q == wm1;
		ctrl_in.fend     = (row_q == hm1) && (col_q == wm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_W'(1);
			fh_q  <= FH_W'(1);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				fw_q <= cfg_data[FW_W-1:0];
			end
			if (cfg_index == REG_FRAME_HEIGHT) begin
				fh_q <= cfg_data[FH_W-1:0];
			end
			if (cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (s_accept) begin
			if (col_q == wm1) begin
				col_q <= '0;
				row_q <= (row_q == hm1) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---------------- stage 1: line store ----------------
	bb3_line_store u_line_store (
		.clk     (clk),
		.wr_en   (v_s1),
		.wr_addr (ctrl_s1.col),
		.wr_data (wr_word),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_data (rd_word)
	);

	// back-to-back access of one column (single-column frame) reads the word
	// being written in the same cycle
	assign eff_word    = fwd_s1 ? fwd_word_s1 : rd_word;
	assign wr_word.older = eff_word.prev;
	assign wr_word.prev  = pix_s1;

	assign new_col.p0 = eff_word.older;
	assign new_col.p1 = eff_word.prev;
	assign new_col.p2 = pix_s1;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pix_s1  <= s_tdata[PIX_W-1:0];
			ctrl_s1 <= ctrl_in;
		end
		fwd_word_s1 <= wr_word;
		ctrl_s2     <= ctrl_s1;
		sum_s3      <= sum_s2;
		cnt_s3      <= cnt_s2;
		ctrl_s3     <= ctrl_s2;
		mask_s3     <= mask_s2;
		ctrl_s4     <= ctrl_s3;
		mask_s4     <= mask_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= s_accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			fwd_s1 <= s_accept && v_s1 && (ctrl_s1.col == col_q);
		end
	end

	// ---------------- stage 2: window cells ----------------
	assign rmask.row0_en = ctrl_s2.row0_en;
	assign rmask.row1_en = ctrl_s2.row1_en;

	bb3_cell u_cell2 (
		.clk (clk), .arst_n (arst_n), .shift (v_s1), .col_in (new_col), .mask (rmask),
		.col_out (cell_col[2]), .top_sum (top_sum[2]), .bot_sum (bot_sum[2])
	);
	bb3_cell u_cell1 (
		.clk (clk), .arst_n (arst_n), .shift (v_s1), .col_in (cell_col[2]), .mask (rmask),
		.col_out (cell_col[1]), .top_sum (top_sum[1]), .bot_sum (bot_sum[1])
	);
	bb3_cell u_cell0 (
		.clk (clk), .arst_n (arst_n), .shift (v_s1), .col_in (cell_col[1]), .mask (rmask),
		.col_out (cell_col[0]), .top_sum (top_sum[0]), .bot_sum (bot_sum[0])
	);

	always_comb begin
		rows_top = ctrl_s2.row0_en ? CNT_W'(3) : CNT_W'(2);
		rows_bot = ctrl_s2.row1_en ? CNT_W'(2) : CNT_W'(1);
		cols_l   = ctrl_s2.col0_en ? CNT_W'(3) : CNT_W'(2);
		cols_r   = ctrl_s2.col1_en ? CNT_W'(2) : CNT_W'(1);

		// results in row-major order: upper-left, upper-right, lower-left, lower-right
		sum_s2[0] = (ctrl_s2.col0_en ? SUM_W'(top_sum[0]) : SUM_W'(0))
			+ SUM_W'(top_sum[1]) + SUM_W'(top_sum[2]);
		sum_s2[1] = (ctrl_s2.col1_en ? SUM_W'(top_sum[1]) : SUM_W'(0))
			+ SUM_W'(top_sum[2]);
		sum_s2[2] = (ctrl_s2.col0_en ? SUM_W'(bot_sum[0]) : SUM_W'(0))
			+ SUM_W'(bot_sum[1]) + SUM_W'(bot_sum[2]);
		sum_s2[3] = (ctrl_s2.col1_en ? SUM_W'(bot_sum[1]) : SUM_W'(0))
			+ SUM_W'(bot_sum[2]);

		cnt_s2[0] = CNT_W'(rows_top * cols_l);
		cnt_s2[1] = CNT_W'(rows_top * cols_r);
		cnt_s2[2] = CNT_W'(rows_bot * cols_l);
		cnt_s2[3] = CNT_W'(rows_bot * cols_r);

		mask_s2[0] = ctrl_s2.row1_en && ctrl_s2.col1_en;
		mask_s2[1] = ctrl_s2.row1_en && ctrl_s2.right_en;
		mask_s2[2] = ctrl_s2.bot_en && ctrl_s2.col1_en;
		mask_s2[3] = ctrl_s2.bot_en && ctrl_s2.right_en;
	end

	// ---------------- stage 3/4: means ----------------
	for (genvar i = 0; i < NUM_RES; i++) begin : g_mean
		bb3_mean u_mean (
			.clk  (clk),
			.sum  (sum_s3[i]),
			.cnt  (cnt_s3[i]),
			.mean (mean_s4[i])
		);
	end

	always_comb begin
		push_data.row  = ctrl_s4.row;
		push_data.col  = ctrl_s4.col;
		push_data.mask = mask_s4;
		push_data.fend = ctrl_s4.fend;
		push_data.pix  = mean_s4;
	end

	assign push = v_s4 && (mask_s4 != '0);

	bb3_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (q_count),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
